>>> sv/assert_macros.svh
// Assertion helpers for the barycentric weight block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TBW_CHECK(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tbw check failed");

// Consequence that must hold in the same cycle as its antecedent.
`define TBW_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbw implication failed");

`endif

>>> sv/tbw_pkg.sv
package tbw_pkg;

  // Field widths.
  localparam int CW = 16;
  localparam int FW = 16;
  localparam int OW = FW + 5;

  // Widths of the intermediate terms: differences, normal, edge normals, dots.
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW + 1;
  localparam int MW = DW + NW + 1;
  localparam int PW = MW + DW + 2;

  // Divider widths: scaled dividend, compare width, quotient bit index.
  localparam int AW = PW + FW;
  localparam int XW = PW + OW + 1;
  localparam int KW = $clog2(OW);
  localparam int LANES = 3;
  localparam int CELLS = OW;

  typedef logic [CW-1:0] coord_t;
  typedef logic [OW-1:0] weight_t;

  // Word that moves from one divider cell to the next.
  typedef struct packed {
    logic [LANES-1:0][AW-1:0] rem;
    logic [LANES-1:0][PW-1:0] den;
    logic [LANES-1:0][OW-1:0] quo;
    logic [LANES-1:0]         big;
    logic [LANES-1:0]         neg;
    logic                     degen;
  } div_t;

endpackage

>>> sv/triangle_barycentric_weights.sv
// Channel | Direction | Fields
// in      | input     | vertex0..2_x/y/z, point_x/y/z (signed, 16 bits each)
// out     | output    | weight_0..2 (signed Q4.16), degenerate, saturated
//
// The pipeline has six arithmetic stages, 21 divider cells and one output stage.
// One word is accepted per cycle unless out stalls with all stages full; every stage and divider cell holds one word.
// Reset clears all valid bits; data registers are not reset.
// A stall on out backs up stage by stage, so in stays ready while any stage is empty.
module triangle_barycentric_weights (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        vertex0_x,
  input  logic signed [15:0]        vertex0_y,
  input  logic signed [15:0]        vertex0_z,
  input  logic signed [15:0]        vertex1_x,
  input  logic signed [15:0]        vertex1_y,
  input  logic signed [15:0]        vertex1_z,
  input  logic signed [15:0]        vertex2_x,
  input  logic signed [15:0]        vertex2_y,
  input  logic signed [15:0]        vertex2_z,
  input  logic signed [15:0]        point_x,
  input  logic signed [15:0]        point_y,
  input  logic signed [15:0]        point_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [20:0]        weight_0,
  output logic signed [20:0]        weight_1,
  output logic signed [20:0]        weight_2,
  output logic                      degenerate,
  output logic                      saturated
);
  import tbw_pkg::*;

  `include "assert_macros.svh"

  coord_t [11:0]       coords;
  logic  [CELLS:0]     cv;
  logic  [CELLS:0]     cr;
  div_t                cd [CELLS+1];
  logic                fin_ready;
  weight_t             w_next [LANES];
  logic  [LANES-1:0]   clip;
  logic                sat_next;

  assign coords = {point_z, point_y, point_x, vertex2_z, vertex2_y, vertex2_x,
                   vertex1_z, vertex1_y, vertex1_x, vertex0_z, vertex0_y, vertex0_x};

  // Products, sums and divider setup.
  tbw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coords    (coords),
    .div_valid (cv[0]),
    .div_ready (cr[0]),
    .div_data  (cd[0])
  );

  // Row of divider cells, most significant quotient bit first.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tbw_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bit_pos   (KW'(CELLS - 1 - i)),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_data   (cd[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_data  (cd[i+1])
    );
  end

  assign fin_ready = !out_valid || out_ready;
  assign cr[CELLS] = fin_ready;

  // Sign, saturation and the degenerate case.
  always_comb begin
    logic [OW-1:0] lim;
    logic [OW-1:0] mag;
    lim = OW'(1) << (OW - 1);
    for (int l = 0; l < LANES; l++) begin
      if (cd[CELLS].neg[l]) begin
        clip[l] = cd[CELLS].big[l] || (cd[CELLS].quo[l] > lim);
        mag = clip[l] ? lim : cd[CELLS].quo[l];
        w_next[l] = OW'(-mag);
      end else begin
        clip[l] = cd[CELLS].big[l] || (cd[CELLS].quo[l] > (lim - OW'(1)));
        mag = clip[l] ? (lim - OW'(1)) : cd[CELLS].quo[l];
        w_next[l] = mag;
      end
      if (cd[CELLS].degen) begin
        w_next[l] = '0;
      end
    end
    sat_next = !cd[CELLS].degen && (clip != '0);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= cv[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && cv[CELLS]) begin
      weight_0   <= w_next[0];
      weight_1   <= w_next[1];
      weight_2   <= w_next[2];
      degenerate <= cd[CELLS].degen;
      saturated  <= sat_next;
    end
  end

  // Input backs up only when every stage is full and the output is stalled.
  `TBW_IMPLIES(a_full_when_blocked, !in_ready, out_valid && !out_ready && cv[CELLS])
  // A degenerate result carries zero weights and no saturation.
  `TBW_IMPLIES(a_degen_zero, out_valid && degenerate,
               weight_0 == '0 && weight_1 == '0 && weight_2 == '0 && !saturated)
  // A word waiting at the divider input means the first cell is full.
  `TBW_IMPLIES(a_front_hold, cv[0] && !cr[0], cv[1])

endmodule

>>> sv/tbw_front.sv
module tbw_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tbw_pkg::coord_t [11:0]          coords,
  output logic                            div_valid,
  input  logic                            div_ready,
  output tbw_pkg::div_t                   div_data
);
  import tbw_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5, r6;

  logic signed [DW-1:0] s1_e [3][3];
  logic signed [DW-1:0] s1_r [3][3];
  logic signed [DW-1:0] s2_e [3][3];
  logic signed [DW-1:0] s2_r [3][3];
  logic signed [NW-1:0] s2_n [3];
  logic signed [DW-1:0] s3_e [3][3];
  logic signed [DW-1:0] s3_r [3][3];
  logic signed [MW-1:0] s3_m [3][3];
  logic signed [MW+DW-1:0] s4_pd [3][3];
  logic signed [MW+DW-1:0] s4_pn [3][3];
  logic signed [PW-1:0] s5_den [3];
  logic signed [PW-1:0] s5_num [3];

  logic signed [DW-1:0] e_next [3][3];
  logic signed [DW-1:0] r_next [3][3];
  logic signed [NW-1:0] n_next [3];
  logic signed [MW-1:0] m_next [3][3];
  logic signed [PW-1:0] den_next [3];
  logic signed [PW-1:0] num_next [3];
  div_t                 div_next;

  // Ready chain: a stage takes a word when it is empty or its word moves on.
  assign r6 = !div_valid || div_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  // Stage 1: edges and vertex-minus-point vectors.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_next[0][c] = DW'($signed(coords[3+c])) - DW'($signed(coords[c]));
      e_next[1][c] = DW'($signed(coords[6+c])) - DW'($signed(coords[3+c]));
      e_next[2][c] = DW'($signed(coords[c])) - DW'($signed(coords[6+c]));
      r_next[0][c] = DW'($signed(coords[3+c])) - DW'($signed(coords[9+c]));
      r_next[1][c] = DW'($signed(coords[6+c])) - DW'($signed(coords[9+c]));
      r_next[2][c] = DW'($signed(coords[c])) - DW'($signed(coords[9+c]));
    end
  end

  // Stage 2: triangle normal from the edge opposite vertex 1 and the first edge.
  always_comb begin
    n_next[0] = NW'(s1_e[2][1] * s1_e[0][2]) - NW'(s1_e[2][2] * s1_e[0][1]);
    n_next[1] = NW'(s1_e[2][2] * s1_e[0][0]) - NW'(s1_e[2][0] * s1_e[0][2]);
    n_next[2] = NW'(s1_e[2][0] * s1_e[0][1]) - NW'(s1_e[2][1] * s1_e[0][0]);
  end

  // Stage 3: in-plane edge normals; lane l uses the edge after it.
  for (genvar l = 0; l < 3; l++) begin : g_edge_normal
    localparam int EI = (l + 1) % 3;
    logic signed [DW+NW-1:0] pa [3];
    logic signed [DW+NW-1:0] pb [3];
    assign pa[0] = s2_e[EI][1] * s2_n[2];
    assign pb[0] = s2_e[EI][2] * s2_n[1];
    assign pa[1] = s2_e[EI][2] * s2_n[0];
    assign pb[1] = s2_e[EI][0] * s2_n[2];
    assign pa[2] = s2_e[EI][0] * s2_n[1];
    assign pb[2] = s2_e[EI][1] * s2_n[0];
    for (genvar c = 0; c < 3; c++) begin : g_comp
      assign m_next[l][c] = MW'(pa[c]) - MW'(pb[c]);
    end
  end

  // Stage 5: dot product sums.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      den_next[l] = PW'(s4_pd[l][0]) + PW'(s4_pd[l][1]) + PW'(s4_pd[l][2]);
      num_next[l] = PW'(s4_pn[l][0]) + PW'(s4_pn[l][1]) + PW'(s4_pn[l][2]);
    end
  end

  // Stage 6: magnitudes, scaled dividend, overflow and degenerate checks.
  always_comb begin
    logic [PW-1:0] an;
    logic [PW-1:0] ad;
    div_next = '0;
    for (int l = 0; l < 3; l++) begin
      an = s5_num[l][PW-1] ? PW'(-s5_num[l]) : PW'(s5_num[l]);
      ad = s5_den[l][PW-1] ? PW'(-s5_den[l]) : PW'(s5_den[l]);
      div_next.rem[l] = {an, FW'(0)};
      div_next.den[l] = ad;
      div_next.quo[l] = '0;
      div_next.neg[l] = s5_num[l][PW-1] ^ s5_den[l][PW-1];
      div_next.big[l] = XW'(div_next.rem[l]) >= (XW'(ad) << OW);
    end
    div_next.degen = (s5_den[0] == '0) || (s5_den[1] == '0) || (s5_den[2] == '0);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      div_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) div_valid <= v5;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_e <= e_next;
      s1_r <= r_next;
    end
    if (r2 && v1) begin
      s2_e <= s1_e;
      s2_r <= s1_r;
      s2_n <= n_next;
    end
    if (r3 && v2) begin
      s3_e <= s2_e;
      s3_r <= s2_r;
      s3_m <= m_next;
    end
    if (r4 && v3) begin
      for (int l = 0; l < 3; l++) begin
        for (int c = 0; c < 3; c++) begin
          s4_pd[l][c] <= s3_m[l][c] * s3_e[l][c];
          s4_pn[l][c] <= s3_m[l][c] * s3_r[l][c];
        end
      end
    end
    if (r5 && v4) begin
      s5_den <= den_next;
      s5_num <= num_next;
    end
    if (r6 && v5) begin
      div_data <= div_next;
    end
  end

endmodule

>>> sv/tbw_div_cell.sv
module tbw_div_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [tbw_pkg::KW-1:0]   bit_pos,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tbw_pkg::div_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tbw_pkg::div_t            out_data
);
  import tbw_pkg::*;

  div_t data_next;

  // One restoring step per lane: settle the quotient bit at bit_pos.
  always_comb begin
    logic [XW-1:0] trial;
    data_next = in_data;
    for (int l = 0; l < LANES; l++) begin
      trial = XW'(in_data.den[l]) << bit_pos;
      if (XW'(in_data.rem[l]) >= trial) begin
        data_next.rem[l] = in_data.rem[l] - AW'(trial);
        data_next.quo[l][bit_pos] = 1'b1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Valid bit of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Word register of the cell.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  import tbw_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic [11:0][CW-1:0] tri_word_t;

  typedef struct packed {
    weight_t w0;
    weight_t w1;
    weight_t w2;
    logic    degen;
    logic    sat;
  } weights_t;

  // Scoreboard: predicts the weights of each accepted word and checks results in order.
  class weight_scoreboard;
    weights_t pending_weights[$];
    int mismatches;

    function wide_t crs(wide_t a[3], wide_t b[3], int k);
      case (k)
        0: crs = a[1] * b[2] - a[2] * b[1];
        1: crs = a[2] * b[0] - a[0] * b[2];
        default: crs = a[0] * b[1] - a[1] * b[0];
      endcase
    endfunction

    function wide_t dot3(wide_t a[3], wide_t b[3]);
      dot3 = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Quotient truncated toward zero into signed Q4.16, clipped at the code range.
    function weight_t fixed_quot(wide_t num, wide_t den, inout logic sat);
      logic  neg;
      wide_t a, b, q;
      wide_t lim;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      a = a <<< FW;
      q = a / b;
      lim = wide_t'(1) <<< (OW - 1);
      if (neg) begin
        if (q > lim) begin
          sat = 1'b1;
          q = lim;
        end
        q = -q;
      end else if (q > lim - 1) begin
        sat = 1'b1;
        q = lim - 1;
      end
      fixed_quot = q[OW-1:0];
    endfunction

    function weights_t weights_of(tri_word_t f);
      wide_t v[4][3];
      wide_t e12[3], e23[3], e31[3], nrm[3], m12[3], m23[3], m31[3];
      wide_t r0[3], r1[3], r2[3];
      wide_t d0, d1, d2;
      weights_t r;
      logic sat;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++)
          v[i][j] = wide_t'($signed(f[i*3+j]));
      for (int j = 0; j < 3; j++) begin
        e12[j] = v[1][j] - v[0][j];
        e23[j] = v[2][j] - v[1][j];
        e31[j] = v[0][j] - v[2][j];
        r0[j] = v[1][j] - v[3][j];
        r1[j] = v[2][j] - v[3][j];
        r2[j] = v[0][j] - v[3][j];
      end
      for (int k = 0; k < 3; k++) nrm[k] = crs(e31, e12, k);
      for (int k = 0; k < 3; k++) begin
        m12[k] = crs(e12, nrm, k);
        m23[k] = crs(e23, nrm, k);
        m31[k] = crs(e31, nrm, k);
      end
      d0 = dot3(m23, e12);
      d1 = dot3(m31, e23);
      d2 = dot3(m12, e31);
      r = '0;
      if (d0 == 0 || d1 == 0 || d2 == 0) begin
        r.degen = 1'b1;
      end else begin
        sat = 1'b0;
        r.w0 = fixed_quot(dot3(m23, r0), d0, sat);
        r.w1 = fixed_quot(dot3(m31, r1), d1, sat);
        r.w2 = fixed_quot(dot3(m12, r2), d2, sat);
        r.sat = sat;
      end
      weights_of = r;
    endfunction

    function void note_input(tri_word_t f);
      pending_weights.push_back(weights_of(f));
    endfunction

    function void check_result(weights_t act);
      weights_t exp_w;
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %p", act);
        return;
      end
      exp_w = pending_weights.pop_front();
      if (act !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: w0 %0d/%0d w1 %0d/%0d w2 %0d/%0d degen %b/%b sat %b/%b",
                   $signed(exp_w.w0), $signed(act.w0), $signed(exp_w.w1), $signed(act.w1),
                   $signed(exp_w.w2), $signed(act.w2), exp_w.degen, act.degen,
                   exp_w.sat, act.sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  tri_word_t drive_word = '0;
  weight_t weight_0, weight_1, weight_2;
  logic degenerate, saturated;

  weight_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  triangle_barycentric_weights dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .vertex0_x(drive_word[0]), .vertex0_y(drive_word[1]), .vertex0_z(drive_word[2]),
    .vertex1_x(drive_word[3]), .vertex1_y(drive_word[4]), .vertex1_z(drive_word[5]),
    .vertex2_x(drive_word[6]), .vertex2_y(drive_word[7]), .vertex2_z(drive_word[8]),
    .point_x(drive_word[9]), .point_y(drive_word[10]), .point_z(drive_word[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2),
    .degenerate(degenerate), .saturated(saturated)
  );

  // Receiver ready, with random stalls and one long hold-off in the first phase.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 150;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{weight_0, weight_1, weight_2, degenerate, saturated});
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_word(tri_word_t f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    drive_word <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f);
    @(negedge clk);
  endtask

  task automatic send_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                          int c0, int c1, int c2, int p0, int p1, int p2);
    tri_word_t f;
    f[0] = CW'(a0); f[1] = CW'(a1); f[2] = CW'(a2);
    f[3] = CW'(b0); f[4] = CW'(b1); f[5] = CW'(b2);
    f[6] = CW'(c0); f[7] = CW'(c1); f[8] = CW'(c2);
    f[9] = CW'(p0); f[10] = CW'(p1); f[11] = CW'(p2);
    send_word(f);
  endtask

  function automatic int rnd_in(int r);
    rnd_in = $urandom_range(2 * r) - r;
    if (rnd_in > 32767) rnd_in = 32767;
    if (rnd_in < -32768) rnd_in = -32768;
  endfunction

  // Random word: mostly triangles at a random scale, some raw, collinear or point-on-vertex.
  task automatic send_random();
    tri_word_t f;
    int r, k, sel;
    sel = $urandom_range(99);
    r = 1 << $urandom_range(1, 15);
    for (int i = 0; i < 12; i++) f[i] = CW'(rnd_in(r));
    if (sel < 15) begin
      for (int i = 0; i < 12; i++) f[i] = CW'($urandom());
    end else if (sel < 25) begin
      // Collinear or coincident vertices.
      k = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) begin
        r = rnd_in(64);
        f[j] = CW'(rnd_in(1000));
        f[3+j] = CW'($signed(f[j]) + r);
        f[6+j] = CW'($signed(f[j]) + k * r);
      end
    end else if (sel < 40) begin
      // Query point on a vertex.
      k = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) f[9+j] = f[3*k+j];
    end
    send_word(f);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words: extremes, vertices, centroid, far points, degenerate cases.
    send_tri(0, 0, 0, 64, 0, 0, 0, 64, 0, 0, 0, 0);
    send_tri(0, 0, 0, 64, 0, 0, 0, 64, 0, 64, 0, 0);
    send_tri(0, 0, 0, 64, 0, 0, 0, 64, 0, 0, 64, 0);
    send_tri(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0);
    send_tri(0, 0, 0, 3, 0, 7, 0, 3, 5, 1, 1, 9);
    send_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
             32767, 32767, 32767);
    send_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
             -32768, -32768, -32768);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 15, 0, 0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 16, 0, 0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, -16, 0, 0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, -17, 0, 0);
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tri(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
             -32768, -32768, -32768);
    send_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
             32767, 32767, 32767);
    send_tri(0, 0, 0, 10, 10, 10, 20, 20, 20, 5, 1, 3);
    send_tri(1, 2, 3, 1, 2, 3, 9, 9, 9, 0, 0, 0);
    send_tri(32767, 0, 0, -32768, 0, 0, 0, 32767, -32768, 0, 0, 32767);
    send_tri(0, 0, 0, 3, 0, 0, 0, 7, 0, 1, 2, 300);

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 58; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 58; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < 160; n++) send_random();
      // Sender pauses until every expected word has come out.
      if (ph == 1) begin
        in_valid <= 1'b0;
        wait (sb.pending_weights.size() == 0);
        @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    wait (sb.pending_weights.size() == 0);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_weights.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/tbw_pkg.sv
sv/tbw_front.sv
sv/tbw_div_cell.sv
sv/triangle_barycentric_weights.sv
tb/tb_top.sv
